/* design/lkvc_pkg.sv */
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared constants and types for the LRU key-value cache: entry count,
// field widths, action codes and the controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  // Number of entries in the store
  localparam int ENTRIES = 16;

  // Derived widths
  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W = IDX_W;
  localparam int CNT_W  = $clog2(ENTRIES + 1);

  // Field widths fixed by the interface
  localparam int KEY_W = 32;
  localparam int VAL_W = 31;
  localparam int CAP_W = 5;

  // Capacity register value after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Action codes
  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_WRITE  = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;   // capture the incoming item
    logic match;  // compare keys, pick hit entry and insert slot
    logic apply;  // update entries and register the result
  } cmd_t;

endpackage

/* design/lkvc_ctrl.sv */
// ----------------------------------------------------------------------------
// lkvc_ctrl
// Sequencer for the cache: takes one item, steps it through the match and
// apply phases, and raises the result strobe after the apply phase.
// ----------------------------------------------------------------------------
module lkvc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output logic          done,
  output lkvc_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_APPLY
  } state_t;

  state_t state;

  // Hold state and the result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) state <= S_MATCH;
        end
        S_MATCH: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          state <= S_IDLE;
          done  <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Decode commands from state
  assign busy      = (state != S_IDLE);
  assign cmd.load  = start && (state == S_IDLE);
  assign cmd.match = (state == S_MATCH);
  assign cmd.apply = (state == S_APPLY);

endmodule

/* design/lkvc_datapath.sv */
// ----------------------------------------------------------------------------
// lkvc_datapath
// Entry storage, parallel key compare, victim and free-slot selection,
// recency rank update and result registers.
// ----------------------------------------------------------------------------
module lkvc_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  lkvc_pkg::cmd_t                cmd,
  input  logic                          capacity_we,
  input  logic [lkvc_pkg::CAP_W-1:0]    capacity,
  input  logic                          action,
  input  logic signed [lkvc_pkg::KEY_W-1:0] key,
  input  logic [lkvc_pkg::VAL_W-1:0]    value,
  output logic                          hit,
  output logic [lkvc_pkg::VAL_W-1:0]    read_value
);

  // Configuration
  logic [lkvc_pkg::CAP_W-1:0] cap_reg;

  // Captured item
  logic                       req_action;
  logic [lkvc_pkg::KEY_W-1:0] req_key;
  logic [lkvc_pkg::VAL_W-1:0] req_value;

  // Entry storage
  logic [lkvc_pkg::KEY_W-1:0]  entry_key   [lkvc_pkg::ENTRIES];
  logic [lkvc_pkg::VAL_W-1:0]  entry_value [lkvc_pkg::ENTRIES];
  logic [lkvc_pkg::ENTRIES-1:0] entry_valid;
  logic [lkvc_pkg::RANK_W-1:0] entry_rank  [lkvc_pkg::ENTRIES];
  logic [lkvc_pkg::CNT_W-1:0]  occupied_count;

  // Match phase results
  logic                        m_hit;
  logic [lkvc_pkg::IDX_W-1:0]  m_idx;
  logic [lkvc_pkg::IDX_W-1:0]  m_slot;
  logic                        m_new;

  // Match phase logic
  logic [lkvc_pkg::ENTRIES-1:0] match_vec;
  logic [lkvc_pkg::ENTRIES-1:0] lru_vec;
  logic [lkvc_pkg::CNT_W-1:0]   eff_cap;
  logic [lkvc_pkg::RANK_W-1:0]  lru_rank;
  logic [lkvc_pkg::CNT_W-1:0]   count_less;
  logic                         full;
  logic                         any_match;
  logic [lkvc_pkg::IDX_W-1:0]   match_idx;
  logic [lkvc_pkg::IDX_W-1:0]   lru_idx;
  logic [lkvc_pkg::IDX_W-1:0]   free_idx;

  // Apply phase logic
  logic [lkvc_pkg::IDX_W-1:0]   target;
  logic                         do_promote;
  logic                         tgt_valid;
  logic [lkvc_pkg::RANK_W-1:0]  tgt_rank;
  logic                         do_insert;

  // Clamp capacity into 1..ENTRIES
  always_comb begin
    if (cap_reg == '0) begin
      eff_cap = lkvc_pkg::CNT_W'(1);
    end else if (int'(cap_reg) > lkvc_pkg::ENTRIES) begin
      eff_cap = lkvc_pkg::CNT_W'(lkvc_pkg::ENTRIES);
    end else begin
      eff_cap = lkvc_pkg::CNT_W'(cap_reg);
    end
  end

  assign full       = (occupied_count >= eff_cap);
  assign count_less = occupied_count - lkvc_pkg::CNT_W'(1);
  assign lru_rank   = count_less[lkvc_pkg::RANK_W-1:0];

  // Compare every entry against the key and the oldest rank
  always_comb begin
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
      match_vec[i] = entry_valid[i] && (entry_key[i] == req_key);
      lru_vec[i]   = entry_valid[i] && (entry_rank[i] == lru_rank);
    end
  end

  // Encode lowest set position of each vector
  always_comb begin
    match_idx = '0;
    lru_idx   = '0;
    free_idx  = '0;
    for (int i = lkvc_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (match_vec[i])    match_idx = lkvc_pkg::IDX_W'(i);
      if (lru_vec[i])      lru_idx   = lkvc_pkg::IDX_W'(i);
      if (!entry_valid[i]) free_idx  = lkvc_pkg::IDX_W'(i);
    end
  end

  assign any_match = |match_vec;

  // Apply phase selections
  assign target     = m_hit ? m_idx : m_slot;
  assign do_promote = m_hit || (req_action == lkvc_pkg::ACT_WRITE);
  assign do_insert  = !m_hit && (req_action == lkvc_pkg::ACT_WRITE);
  assign tgt_valid  = entry_valid[target];
  assign tgt_rank   = entry_rank[target];

  // Capture item and match results
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_action <= action;
      req_key    <= key;
      req_value  <= value;
    end
    if (cmd.match) begin
      m_hit  <= any_match;
      m_idx  <= match_idx;
      m_slot <= full ? lru_idx : free_idx;
      m_new  <= !full;
    end
  end

  // Write key and value of the target entry
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      if (do_insert) entry_key[target] <= req_key;
      if (req_action == lkvc_pkg::ACT_WRITE) entry_value[target] <= req_value;
    end
  end

  // Register the result
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      hit <= m_hit;
      if (m_hit && (req_action == lkvc_pkg::ACT_LOOKUP)) begin
        read_value <= entry_value[m_idx];
      end else begin
        read_value <= '0;
      end
    end
  end

  // Hold capacity, valid bits, ranks and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg        <= lkvc_pkg::CAP_RESET;
      entry_valid    <= '0;
      occupied_count <= '0;
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
        entry_rank[i] <= '0;
      end
    end else begin
      if (capacity_we) cap_reg <= capacity;
      if (cmd.apply && do_promote) begin
        // Age every entry more recent than the target, then make it newest
        for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
          if (lkvc_pkg::IDX_W'(i) == target) begin
            entry_rank[i] <= '0;
          end else if (entry_valid[i] && (!tgt_valid || (entry_rank[i] < tgt_rank))) begin
            entry_rank[i] <= entry_rank[i] + lkvc_pkg::RANK_W'(1);
          end
        end
        if (do_insert) begin
          entry_valid[target] <= 1'b1;
          if (m_new) occupied_count <= occupied_count + lkvc_pkg::CNT_W'(1);
        end
      end
    end
  end

endmodule

/* design/lru_key_value_cache.sv */
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive action, key and value and raise start. The item is taken
//   at a rising edge where start is high and busy is low. action 0 looks the
//   key up, action 1 writes the key with value (inserting it if absent and
//   evicting the least recent entry once the store holds capacity entries).
//   Result: done is high for exactly one cycle with hit and read_value;
//   read_value carries the stored value on a lookup hit and zero otherwise.
//   The receiver must take it in that cycle; there is no back-pressure.
//   Sequence: the item passes the key-compare phase and then the update
//   phase; done rises in the same cycle that busy falls. The controller's
//   fixed compare/update sequence takes no new item while busy is high.
//   Configuration: capacity_we writes capacity (clamped to 1..16); the user
//   must do so only while idle, which the block does not enforce.
//   Reset: rst (synchronous) empties the store and sets capacity to 16.
// ----------------------------------------------------------------------------
module lru_key_value_cache (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              action,
  input  logic signed [lkvc_pkg::KEY_W-1:0] key,
  input  logic [lkvc_pkg::VAL_W-1:0]        value,
  input  logic                              capacity_we,
  input  logic [lkvc_pkg::CAP_W-1:0]        capacity,
  output logic                              done,
  output logic                              hit,
  output logic [lkvc_pkg::VAL_W-1:0]        read_value
);

  lkvc_pkg::cmd_t cmd;

  // Sequencer
  lkvc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // Storage and compare logic
  lkvc_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .capacity_we (capacity_we),
    .capacity    (capacity),
    .action      (action),
    .key         (key),
    .value       (value),
    .hit         (hit),
    .read_value  (read_value)
  );

  // Only one phase command at a time
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.match, cmd.apply}))
    else $error("more than one phase command active");

  // Result strobe follows the update phase
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.apply))
    else $error("done without a preceding update phase");

  // An accepted item keeps the block busy for the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && cmd.match))
    else $error("accepted item did not enter the compare phase");

  // The block is free again when the result shows
  assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("busy while result strobe is high");

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LRU key-value cache. A queue of lookups, writes,
// capacity changes and drain points feeds a clocked driver; a clocked monitor
// compares each done strobe with the answer of a behavioral LRU store
// computed when the item is taken.
// ----------------------------------------------------------------------------
module tb;

  typedef enum logic [1:0] {OP_ITEM, OP_CAPACITY, OP_DRAIN} op_kind_t;

  typedef struct {
    op_kind_t                   kind;
    logic                       action;
    logic [lkvc_pkg::KEY_W-1:0] key;
    logic [lkvc_pkg::VAL_W-1:0] value;
    int                         gap;
    logic [lkvc_pkg::CAP_W-1:0] cap;
  } pending_op_t;

  typedef struct {
    logic                       hit;
    logic [lkvc_pkg::VAL_W-1:0] read_value;
  } answer_t;

  // DUT ports
  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              start = 1'b0;
  logic                              busy;
  logic                              action = lkvc_pkg::ACT_LOOKUP;
  logic signed [lkvc_pkg::KEY_W-1:0] key = '0;
  logic [lkvc_pkg::VAL_W-1:0]        value = '0;
  logic                              capacity_we = 1'b0;
  logic [lkvc_pkg::CAP_W-1:0]        capacity = lkvc_pkg::CAP_RESET;
  logic                              done;
  logic                              hit;
  logic [lkvc_pkg::VAL_W-1:0]        read_value;

  // Behavioral copy of the store
  logic [lkvc_pkg::KEY_W-1:0] m_key [lkvc_pkg::ENTRIES];
  logic [lkvc_pkg::VAL_W-1:0] m_value [lkvc_pkg::ENTRIES];
  logic                       m_valid [lkvc_pkg::ENTRIES];
  int                         m_rank [lkvc_pkg::ENTRIES];
  int                         m_count;
  logic [lkvc_pkg::CAP_W-1:0] m_capacity;

  pending_op_t request_q[$];
  answer_t     answer_q[$];
  int          gap_left = 0;
  int          errors = 0;

  lru_key_value_cache DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .action     (action),
    .key        (key),
    .value      (value),
    .capacity_we(capacity_we),
    .capacity   (capacity),
    .done       (done),
    .hit        (hit),
    .read_value (read_value)
  );

  // Clock and reset
  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  // Give up after a generous time
  initial begin
    #200000;
    $display("tb: done, errors");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("tb: mismatch: %s", msg);
    errors++;
  endtask

  // Make one slot the most recent; every entry newer than its old rank ages
  function automatic void make_recent(input int slot);
    int old_rank;
    old_rank = m_valid[slot] ? m_rank[slot] : (1 << 30);
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
      if (i != slot && m_valid[i] && m_rank[i] < old_rank) m_rank[i]++;
    end
    m_rank[slot] = 0;
  endfunction

  // Apply one access to the store copy and return the answer it gives
  function automatic answer_t predict_access(input logic act,
                                             input logic [lkvc_pkg::KEY_W-1:0] k,
                                             input logic [lkvc_pkg::VAL_W-1:0] v);
    answer_t ans;
    int      found;
    int      slot;
    int      worst;
    int      limit;
    found = -1;
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
      if (found < 0 && m_valid[i] && m_key[i] == k) found = i;
    end
    ans.hit = (found >= 0);
    ans.read_value = '0;
    if (act == lkvc_pkg::ACT_LOOKUP) begin
      if (found >= 0) begin
        ans.read_value = m_value[found];
        make_recent(found);
      end
      return ans;
    end
    if (found >= 0) begin
      m_value[found] = v;
      make_recent(found);
      return ans;
    end
    // New key: evict the oldest once the limit is reached, else take a free slot
    limit = (m_capacity == 0) ? 1 :
            (m_capacity > lkvc_pkg::ENTRIES) ? lkvc_pkg::ENTRIES : int'(m_capacity);
    slot = -1;
    if (m_count >= limit) begin
      worst = -1;
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
        if (m_valid[i] && m_rank[i] > worst) begin
          worst = m_rank[i];
          slot = i;
        end
      end
    end
    if (slot < 0) begin
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
        if (slot < 0 && !m_valid[i]) slot = i;
      end
      m_count++;
    end
    make_recent(slot);
    m_valid[slot] = 1'b1;
    m_key[slot] = k;
    m_value[slot] = v;
    return ans;
  endfunction

  // Driver: take items from the request queue, honor gaps and drain points
  always @(posedge clk) begin : drive_proc
    logic        n_start;
    logic        n_we;
    logic        taken;
    pending_op_t op;
    if (rst) begin
      start <= 1'b0;
      capacity_we <= 1'b0;
    end else begin
      taken = start && !busy;
      if (taken) answer_q.push_back(predict_access(action, key, value));
      n_start = start && !taken;
      n_we = 1'b0;
      if (!n_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_q.size() > 0) begin
          op = request_q[0];
          case (op.kind)
            OP_ITEM: begin
              void'(request_q.pop_front());
              n_start = 1'b1;
              action <= op.action;
              key <= op.key;
              value <= op.value;
              gap_left = op.gap;
            end
            OP_CAPACITY: begin
              if (!taken && !busy && answer_q.size() == 0) begin
                void'(request_q.pop_front());
                n_we = 1'b1;
                capacity <= op.cap;
                m_capacity = op.cap;
              end
            end
            default: begin
              if (answer_q.size() == 0) void'(request_q.pop_front());
            end
          endcase
        end
      end
      start <= n_start;
      capacity_we <= n_we;
    end
  end

  // Monitor: check each strobed result against the oldest answer
  always @(posedge clk) begin : check_proc
    answer_t exp_ans;
    if (!rst && done) begin
      if (answer_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending hit=%0b value=%0h",
                                  hit, read_value));
      end else begin
        exp_ans = answer_q.pop_front();
        if (hit !== exp_ans.hit)
          report_mismatch($sformatf("hit got %0b want %0b", hit, exp_ans.hit));
        if (read_value !== exp_ans.read_value)
          report_mismatch($sformatf("read_value got %0h want %0h",
                                    read_value, exp_ans.read_value));
      end
    end
  end

  task automatic add_item(input logic act, input logic [lkvc_pkg::KEY_W-1:0] k,
                          input logic [lkvc_pkg::VAL_W-1:0] v, input int gap);
    pending_op_t op;
    op.kind = OP_ITEM;
    op.action = act;
    op.key = k;
    op.value = v;
    op.gap = gap;
    op.cap = '0;
    request_q.push_back(op);
  endtask

  task automatic add_capacity(input logic [lkvc_pkg::CAP_W-1:0] c);
    pending_op_t op;
    op.kind = OP_CAPACITY;
    op.action = lkvc_pkg::ACT_LOOKUP;
    op.key = '0;
    op.value = '0;
    op.gap = 0;
    op.cap = c;
    request_q.push_back(op);
  endtask

  task automatic add_drain();
    pending_op_t op;
    op.kind = OP_DRAIN;
    op.action = lkvc_pkg::ACT_LOOKUP;
    op.key = '0;
    op.value = '0;
    op.gap = 0;
    op.cap = '0;
    request_q.push_back(op);
  endtask

  // Stimulus and end of run
  initial begin : stim_proc
    logic [lkvc_pkg::KEY_W-1:0] pool [32];
    logic [lkvc_pkg::CAP_W-1:0] phase_cap [13];
    logic [lkvc_pkg::VAL_W-1:0] v;
    logic                       act;
    int                         pool_size;
    int                         write_pct;
    bit                         quiet;

    // Empty store after reset
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
      m_key[i] = '0;
      m_value[i] = '0;
      m_valid[i] = 1'b0;
      m_rank[i] = 0;
    end
    m_count = 0;
    m_capacity = lkvc_pkg::CAP_RESET;

    // Directed: empty lookup, key extremes, updates, ignored value on lookup
    add_item(lkvc_pkg::ACT_LOOKUP, 32'h0000_0000, 31'h0, 0);
    add_item(lkvc_pkg::ACT_WRITE, 32'h8000_0000, 31'h0, 0);
    add_item(lkvc_pkg::ACT_WRITE, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1);
    add_item(lkvc_pkg::ACT_WRITE, 32'hFFFF_FFFF, 31'h1, 0);
    add_item(lkvc_pkg::ACT_WRITE, 32'h0000_0000, 31'h5555_5555, 2);
    add_item(lkvc_pkg::ACT_LOOKUP, 32'h8000_0000, 31'h7FFF_FFFF, 0);
    add_item(lkvc_pkg::ACT_LOOKUP, 32'h7FFF_FFFF, 31'h0, 0);
    add_item(lkvc_pkg::ACT_WRITE, 32'hFFFF_FFFF, 31'h2AAA_AAAA, 0);
    add_item(lkvc_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 31'h0, 3);
    add_item(lkvc_pkg::ACT_LOOKUP, 32'h1234_5678, 31'h7FFF_FFFF, 0);
    // Capacity lowered below occupancy: old entries still hit, inserts replace
    add_capacity(5'd2);
    add_item(lkvc_pkg::ACT_LOOKUP, 32'h0000_0000, 31'h0, 0);
    add_item(lkvc_pkg::ACT_WRITE, 32'hA5A5_A5A5, 31'h1234_5678, 0);
    add_item(lkvc_pkg::ACT_LOOKUP, 32'h8000_0000, 31'h0, 0);
    add_item(lkvc_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 31'h0, 0);
    add_item(lkvc_pkg::ACT_WRITE, 32'h5A5A_5A5A, 31'h0ABC_DEF0, 0);
    add_item(lkvc_pkg::ACT_LOOKUP, 32'hA5A5_A5A5, 31'h0, 0);
    // Capacity zero acts as one
    add_capacity(5'd0);
    add_item(lkvc_pkg::ACT_WRITE, 32'h0000_0001, 31'h11, 0);
    add_item(lkvc_pkg::ACT_WRITE, 32'h0000_0002, 31'h22, 0);
    add_item(lkvc_pkg::ACT_LOOKUP, 32'h0000_0002, 31'h0, 0);
    // Capacity above the entry count saturates
    add_capacity(5'd31);
    add_item(lkvc_pkg::ACT_WRITE, 32'h0000_0003, 31'h33, 0);
    add_item(lkvc_pkg::ACT_LOOKUP, 32'h0000_0001, 31'h0, 0);
    add_item(lkvc_pkg::ACT_LOOKUP, 32'h0000_0003, 31'h0, 0);

    // Random phases: a key pool per phase so lookups hit and inserts evict
    phase_cap = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd8, 5'd17, 5'd4,
                  5'd3, 5'd16, 5'd5, 5'd12, 5'd1};
    phase_cap[7] = 5'($urandom_range(1, 16));
    phase_cap[11] = 5'($urandom_range(0, 31));
    for (int ph = 0; ph < 13; ph++) begin
      add_capacity(phase_cap[ph]);
      pool_size = $urandom_range(2, 24);
      write_pct = $urandom_range(25, 70);
      quiet = (ph % 4 == 1);
      for (int i = 0; i < pool_size; i++) pool[i] = $urandom;
      pool[0] = (ph % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      if (pool_size > 2) pool[1] = (ph % 3 == 0) ? 32'hFFFF_FFFF : 32'h0;
      for (int n = 0; n < 50; n++) begin
        if (n == 25 && (ph % 4 == 3)) add_drain();
        act = ($urandom_range(0, 99) < write_pct) ? lkvc_pkg::ACT_WRITE
                                                  : lkvc_pkg::ACT_LOOKUP;
        case ($urandom_range(0, 9))
          0: v = '0;
          1: v = 31'h7FFF_FFFF;
          default: v = 31'($urandom);
        endcase
        add_item(act, ($urandom_range(0, 9) == 0) ? 32'($urandom)
                                                  : pool[$urandom_range(0, pool_size - 1)],
                 v, quiet ? 0 : $urandom_range(0, 5));
      end
    end

    // Drain everything, then allow time for stray strobes
    while (request_q.size() != 0 || start || answer_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

/* lru_key_value_cache.f */
design/lkvc_pkg.sv
design/lkvc_ctrl.sv
design/lkvc_datapath.sv
design/lru_key_value_cache.sv
test/tb.sv
